FILE: design/jadm_pkg.sv
// Shared constants and types for the joystick axis median and deadzone mapper.
package jadm_pkg;

  localparam int AXIS_W         = 2;
  localparam int SAMPLE_W       = 12;
  localparam int EDGE_W         = 14;
  localparam int STICK_W        = 10;
  localparam int REG_AXES       = 4;
  localparam int CFG_IDX_W      = 3;
  localparam int NUM_AXES_DEF   = 4;
  localparam int FULL_SCALE_DEF = 500;
  localparam int ADC_MAX        = 4095;
  localparam int DEAD_LOW_RST   = 1800;
  localparam int DEAD_HIGH_RST  = 2200;
  localparam int STICK_MAX      = 511;
  localparam int STICK_MIN      = -512;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MED,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: design/jadm_hist.sv
// Per-axis three-sample history with median-of-three select.
module jadm_hist #(
  parameter int NUM_AXES = jadm_pkg::NUM_AXES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [jadm_pkg::AXIS_W-1:0]   axis_i,
  input  logic [jadm_pkg::SAMPLE_W-1:0] sample_i,
  output logic [jadm_pkg::SAMPLE_W-1:0] median_o
);

  logic [jadm_pkg::SAMPLE_W-1:0] hist_q [NUM_AXES][3];
  logic [jadm_pkg::SAMPLE_W-1:0] mid, newest;
  logic [jadm_pkg::SAMPLE_W-1:0] lo_ab, hi_ab, lo_hc;

  // mid and newest of the selected row become the two oldest after the shift
  always_comb begin
    mid    = '0;
    newest = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (int'(axis_i) == a) begin
        mid    = hist_q[a][1];
        newest = hist_q[a][2];
      end
    end
  end

  // median = max(min(a,b), min(max(a,b),c))
  always_comb begin
    lo_ab    = (mid < newest) ? mid : newest;
    hi_ab    = (mid > newest) ? mid : newest;
    lo_hc    = (hi_ab < sample_i) ? hi_ab : sample_i;
    median_o = (lo_ab > lo_hc) ? lo_ab : lo_hc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        for (int k = 0; k < 3; k++) begin
          hist_q[a][k] <= '0;
        end
      end
    end else if (wr_en_i) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (int'(axis_i) == a) begin
          hist_q[a][0] <= hist_q[a][1];
          hist_q[a][1] <= hist_q[a][2];
          hist_q[a][2] <= sample_i;
        end
      end
    end
  end

endmodule

FILE: design/jadm_div.sv
// Iterative shift-subtract divider, one quotient bit per cycle.
module jadm_div #(
  parameter int FULL_SCALE_OUT = jadm_pkg::FULL_SCALE_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        start_i,
  input  logic [jadm_pkg::EDGE_W+$clog2(FULL_SCALE_OUT+1)-1:0] num_i,
  input  logic [jadm_pkg::EDGE_W-1:0]                 den_i,
  output jadm_pkg::div_stat_t                         stat_o,
  output logic [$clog2(FULL_SCALE_OUT+1)-1:0]         quo_o
);

  localparam int QW = $clog2(FULL_SCALE_OUT + 1);
  localparam int NW = jadm_pkg::EDGE_W + QW;
  localparam int CW = (QW > 1) ? $clog2(QW) : 1;

  logic [NW-1:0] rem_q, rem_d, dsh_q, dsh_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic          ge;

  // quotient never exceeds FULL_SCALE_OUT, so QW trial subtractions suffice
  always_comb begin
    ge     = (rem_q >= dsh_q);
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num_i;
      dsh_d  = NW'(den_i) << (QW - 1);
      quo_d  = '0;
      cnt_d  = CW'(QW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? (rem_q - dsh_q) : rem_q;
      dsh_d = dsh_q >> 1;
      quo_d = (quo_q << 1) | QW'(ge);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

endmodule

FILE: design/joystick_axis_median_deadzone_map.sv
// Top level: joystick axis median filter with per-axis deadzone map.
//
// - Input channel (in_valid_i / in_stall_o): one transaction carries an axis
//   index and a 12-bit sample. in_stall_o is low only in the idle state; only
//   one item is in the core at a time.
// - Output channel (out_valid_o / out_stall_i): one transaction per input with
//   the echoed axis, the median of the axis's last three samples and the
//   signed deadzone-mapped stick value.
// - Config port: cfg_we_i writes cfg_data_i into deadzone edge cfg_idx_i
//   (even index = low edge, odd = high edge, axis = index / 2).
// - Timing: an item passes the median stage, set-up (compare and multiply)
//   and the shared shift-subtract divider, then loads the output register;
//   the core returns to idle to take the next item. Items inside the
//   deadzone, and absent axes, skip the divider.
// - While a result waits in the output register under out_stall_i, one more
//   item can be taken; the core then holds its result and in_stall_o stays
//   high until the output register is free.
// - Reset clears history to zero and sets edges to 1800 / 2200.
module joystick_axis_median_deadzone_map #(
  parameter int NUM_AXES       = jadm_pkg::NUM_AXES_DEF,
  parameter int FULL_SCALE_OUT = jadm_pkg::FULL_SCALE_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [jadm_pkg::AXIS_W-1:0]          axis_i,
  input  logic [jadm_pkg::SAMPLE_W-1:0]        sample_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [jadm_pkg::AXIS_W-1:0]          axis_out_o,
  output logic [jadm_pkg::SAMPLE_W-1:0]        filtered_o,
  output logic signed [jadm_pkg::STICK_W-1:0]  stick_value_o,
  // config write port
  input  logic                                 cfg_we_i,
  input  logic [jadm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [jadm_pkg::EDGE_W-1:0]          cfg_data_i
);

  localparam int QW = $clog2(FULL_SCALE_OUT + 1);  // quotient width
  localparam int NW = jadm_pkg::EDGE_W + QW;       // dividend width
  localparam int XW = jadm_pkg::EDGE_W + 1;        // edge compare width

  jadm_pkg::state_e state_q, state_d;

  // accepted transaction
  logic [jadm_pkg::AXIS_W-1:0]   ax_q;
  logic [jadm_pkg::SAMPLE_W-1:0] smp_q;
  logic                          ax_ok;

  // deadzone edges
  logic signed [jadm_pkg::EDGE_W-1:0] dead_low_q  [jadm_pkg::REG_AXES];
  logic signed [jadm_pkg::EDGE_W-1:0] dead_high_q [jadm_pkg::REG_AXES];

  // datapath
  logic [jadm_pkg::SAMPLE_W-1:0]        median, med_q;
  logic                                 lower_q;
  logic signed [jadm_pkg::STICK_W-1:0]  res_q, res_d;
  logic signed [XW-1:0]                 m_x, lo_x, hi_x, diff_x, span_x;
  logic                                 below, above;
  logic [jadm_pkg::EDGE_W-1:0]          factor, den;
  logic [NW-1:0]                        num;
  logic [QW-1:0]                        quo;
  int                                   rv;

  // control
  logic                  hist_wr, div_start, core_done, out_load;
  jadm_pkg::div_stat_t   div_stat;

  // output register
  logic                                 out_valid_q;
  logic [jadm_pkg::AXIS_W-1:0]          axis_out_q;
  logic [jadm_pkg::SAMPLE_W-1:0]        filt_q;
  logic signed [jadm_pkg::STICK_W-1:0]  stick_q;

  assign ax_ok = int'(ax_q) < NUM_AXES;

  jadm_hist #(
    .NUM_AXES (NUM_AXES)
  ) u_hist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (hist_wr),
    .axis_i   (ax_q),
    .sample_i (smp_q),
    .median_o (median)
  );

  // edge compares and divider operands, evaluated in set-up
  always_comb begin
    m_x    = signed'(XW'(med_q));
    lo_x   = XW'(dead_low_q[ax_q]);
    hi_x   = XW'(dead_high_q[ax_q]);
    below  = (m_x < lo_x);
    above  = (m_x > hi_x);
    diff_x = m_x - hi_x;
    span_x = XW'(jadm_pkg::ADC_MAX) - hi_x;
    // below low: m*F/low, low >= 1 here; above high: (m-high)*F/(4095-high)
    factor = below ? jadm_pkg::EDGE_W'(med_q) : diff_x[jadm_pkg::EDGE_W-1:0];
    den    = below ? lo_x[jadm_pkg::EDGE_W-1:0] : span_x[jadm_pkg::EDGE_W-1:0];
    num    = NW'(factor) * NW'(FULL_SCALE_OUT);
  end

  jadm_div #(
    .FULL_SCALE_OUT (FULL_SCALE_OUT)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .stat_o  (div_stat),
    .quo_o   (quo)
  );

  // final offset and clamp to the 10-bit output
  always_comb begin
    rv = lower_q ? (int'(quo) - FULL_SCALE_OUT) : int'(quo);
    if (rv > jadm_pkg::STICK_MAX) begin
      rv = jadm_pkg::STICK_MAX;
    end
    if (rv < jadm_pkg::STICK_MIN) begin
      rv = jadm_pkg::STICK_MIN;
    end
    res_d = jadm_pkg::STICK_W'(rv);
  end

  // sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      jadm_pkg::ST_IDLE: if (in_valid_i) state_d = jadm_pkg::ST_MED;
      jadm_pkg::ST_MED:  state_d = jadm_pkg::ST_PREP;
      jadm_pkg::ST_PREP: begin
        if (ax_ok && (below || above)) begin
          state_d = jadm_pkg::ST_DIV;
        end else begin
          state_d = jadm_pkg::ST_DONE;
        end
      end
      jadm_pkg::ST_DIV:  if (div_stat.done) state_d = jadm_pkg::ST_DONE;
      jadm_pkg::ST_DONE: if (out_load) state_d = jadm_pkg::ST_IDLE;
      default:           state_d = jadm_pkg::ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_stall_o = 1'b1;
    hist_wr    = 1'b0;
    div_start  = 1'b0;
    core_done  = 1'b0;
    unique case (state_q)
      jadm_pkg::ST_IDLE: in_stall_o = 1'b0;
      jadm_pkg::ST_MED:  hist_wr    = ax_ok;
      jadm_pkg::ST_PREP: div_start  = ax_ok && (below || above);
      jadm_pkg::ST_DIV:  ;
      jadm_pkg::ST_DONE: core_done  = 1'b1;
      default:           ;
    endcase
  end

  assign out_load = core_done && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jadm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      for (int a = 0; a < jadm_pkg::REG_AXES; a++) begin
        dead_low_q[a]  <= jadm_pkg::EDGE_W'(jadm_pkg::DEAD_LOW_RST);
        dead_high_q[a] <= jadm_pkg::EDGE_W'(jadm_pkg::DEAD_HIGH_RST);
      end
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        if (cfg_idx_i[0]) begin
          dead_high_q[cfg_idx_i[jadm_pkg::CFG_IDX_W-1:1]] <= cfg_data_i;
        end else begin
          dead_low_q[cfg_idx_i[jadm_pkg::CFG_IDX_W-1:1]] <= cfg_data_i;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == jadm_pkg::ST_IDLE && in_valid_i) begin
      ax_q  <= axis_i;
      smp_q <= sample_i;
    end
    if (state_q == jadm_pkg::ST_MED) begin
      med_q <= ax_ok ? median : '0;
    end
    if (state_q == jadm_pkg::ST_PREP) begin
      lower_q <= below;
      res_q   <= '0;
    end
    if (state_q == jadm_pkg::ST_DIV && div_stat.done) begin
      res_q <= res_d;
    end
    if (out_load) begin
      axis_out_q <= ax_q;
      filt_q     <= med_q;
      stick_q    <= res_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign axis_out_o    = axis_out_q;
  assign filtered_o    = filt_q;
  assign stick_value_o = stick_q;

`ifndef NO_ASSERTIONS
  a_take_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == jadm_pkg::ST_MED)
    else $error("accepted transaction did not start the median stage");

  a_div_busy_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy || div_stat.done |-> state_q == jadm_pkg::ST_DIV)
    else $error("divider active outside the divide state");

  a_stick_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(stick_value_o) <= FULL_SCALE_OUT) &&
                    (int'(stick_value_o) >= -FULL_SCALE_OUT))
    else $error("stick value beyond full scale");
`endif

endmodule
